[sv/rrcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrcs_pkg
// Shared types, register indexes, shape codes and constants for the rotated
// region cell selector.
// ----------------------------------------------------------------------------
package rrcs_pkg;

  // default widths of the stream fields
  localparam int COORD_WIDTH_DEF = 21;
  localparam int RES_WIDTH_DEF   = 32;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SELMIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SELMAX = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REPL   = 3'd6;

  // region shapes
  localparam logic [1:0] SHAPE_ELLIPSOID = 2'd0;
  localparam logic [1:0] SHAPE_BOX       = 2'd1;
  localparam logic [1:0] SHAPE_CYLINDER  = 2'd2;

  // cos/sin words are Q2.30
  localparam int ROT_W    = 32;
  localparam int ROT_FRAC = 30;
  // rotated coordinates are held in a 64-bit word at most
  localparam int ROT_ACC_MAX = 64;

  // limb width of the pipelined multipliers
  localparam int LIMB_W  = 32;
  localparam int MUL_LAT = 3;

  typedef struct packed {
    logic [1:0]         shape;
    logic [62:0]        center;    // x, y, z signed, x lowest
    logic [62:0]        half_len;  // x, y, z unsigned, x lowest
    logic [63:0]        rot;       // cos [63:32], sin [31:0]
    logic signed [31:0] sel_min;
    logic signed [31:0] sel_max;
    logic signed [31:0] repl;
  } cfg_t;

  // cos = 1.0 in Q2.30, sin = 0
  localparam logic [63:0] ROT_RESET = 64'h4000_0000_0000_0000;

  localparam cfg_t CFG_RESET = '{
    shape:    SHAPE_ELLIPSOID,
    center:   63'd0,
    half_len: 63'd0,
    rot:      ROT_RESET,
    sel_min:  32'sd6554,
    sel_max:  32'sd655360000,
    repl:     -32'sd65536
  };

  // width of a rotated coordinate: difference bit plus product plus sum bit,
  // capped at the 64-bit accumulator word
  function automatic int rot_width(input int cw);
    int w;
    w = cw + 1 + ROT_W + 1;
    rot_width = (w > ROT_ACC_MAX) ? ROT_ACC_MAX : w;
  endfunction

endpackage

[sv/rrcs_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrcs_mul
// Pipelined unsigned multiplier built from 32x32 limb products: partial
// products, then row sums, then the final sum; three register stages.
// ----------------------------------------------------------------------------
module rrcs_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic [AW+BW-1:0] p_o
);
  import rrcs_pkg::*;

  localparam int LW  = LIMB_W;
  localparam int NA  = (AW + LW - 1) / LW;
  localparam int NB  = (BW + LW - 1) / LW;
  localparam int PPW = 2 * LW;
  localparam int RW  = (NB + 1) * LW;
  localparam int PW  = AW + BW;

  logic [NA*LW-1:0] a_ext;
  logic [NB*LW-1:0] b_ext;
  logic [PPW-1:0]   pp_q  [NA][NB];
  logic [RW-1:0]    row_d [NA];
  logic [RW-1:0]    row_q [NA];
  logic [PW-1:0]    p_d;
  logic [PW-1:0]    p_q;

  assign a_ext = (NA*LW)'(a_i);
  assign b_ext = (NB*LW)'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= PPW'(a_ext[i*LW +: LW]) * PPW'(b_ext[j*LW +: LW]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_d[i] = row_d[i] + (RW'(pp_q[i][j]) << (j * LW));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_q <= row_d;
    end
  end

  // true product fits PW bits, so the sum wraps harmlessly
  always_comb begin
    p_d = '0;
    for (int i = 0; i < NA; i++) begin
      p_d = p_d + (PW'(row_q[i]) << (i * LW));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

[sv/rrcs_rotate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrcs_rotate
// Front end: captures the point, subtracts the region center, rotates x,y by
// minus the angle and takes magnitudes. Also forms the half-length products.
// Five register stages.
// ----------------------------------------------------------------------------
module rrcs_rotate #(
  parameter int COORD_WIDTH = 21
) (
  input  logic                                          clk_i,
  input  logic                                          en_i,
  input  rrcs_pkg::cfg_t                                cfg_i,
  input  logic signed [COORD_WIDTH-1:0]                 pos_x_i,
  input  logic signed [COORD_WIDTH-1:0]                 pos_y_i,
  input  logic signed [COORD_WIDTH-1:0]                 pos_z_i,
  output logic [rrcs_pkg::rot_width(COORD_WIDTH)-1:0]   ax_o,
  output logic [rrcs_pkg::rot_width(COORD_WIDTH)-1:0]   ay_o,
  output logic [COORD_WIDTH:0]                          az_o,
  output logic [2*COORD_WIDTH-1:0]                      hyq_o,
  output logic [2*COORD_WIDTH-1:0]                      hxq_o,
  output logic [2*COORD_WIDTH-1:0]                      hxhy_o
);
  import rrcs_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = CW + 1;
  localparam int PW  = DW + ROT_W;
  localparam int XW  = rot_width(CW);
  localparam int PKW = 3 * CW;
  localparam int HW  = 2 * CW;

  logic [PKW-1:0]         ctr_ext, half_ext;
  logic signed [CW-1:0]   cx, cy, cz;
  logic [CW-1:0]          hx, hy, hz, q;
  logic signed [ROT_W-1:0] rot_c, rot_s;

  // stage 0: capture
  logic signed [CW-1:0] s0_x_q, s0_y_q, s0_z_q;
  // stage 1: offsets
  logic signed [DW-1:0] s1_dx_q, s1_dy_q, s1_dz_q;
  // stage 2: rotation products
  logic signed [PW-1:0] s2_pxc_q, s2_pys_q, s2_pyc_q, s2_pxs_q;
  logic [DW-1:0]        s2_az_q;
  logic [HW-1:0]        s2_hyq_q, s2_hxq_q, s2_hxhy_q;
  // stage 3: rotated coordinates
  logic signed [PW:0]   x_sum, y_sum;
  logic signed [XW-1:0] s3_x_q, s3_y_q;
  logic [DW-1:0]        s3_az_q;
  logic [HW-1:0]        s3_hyq_q, s3_hxq_q, s3_hxhy_q;
  // stage 4: magnitudes
  logic [XW-1:0]        s4_ax_q, s4_ay_q;
  logic [DW-1:0]        s4_az_q;
  logic [HW-1:0]        s4_hyq_q, s4_hxq_q, s4_hxhy_q;

  assign ctr_ext  = PKW'(cfg_i.center);
  assign half_ext = PKW'(cfg_i.half_len);
  assign cx = $signed(ctr_ext[0 +: CW]);
  assign cy = $signed(ctr_ext[CW +: CW]);
  assign cz = $signed(ctr_ext[2*CW +: CW]);
  assign hx = half_ext[0 +: CW];
  assign hy = half_ext[CW +: CW];
  assign hz = half_ext[2*CW +: CW];
  assign rot_c = $signed(cfg_i.rot[2*ROT_W-1:ROT_W]);
  assign rot_s = $signed(cfg_i.rot[ROT_W-1:0]);

  // the cylinder has no z weight
  assign q = (cfg_i.shape == SHAPE_ELLIPSOID) ? hz : CW'(1);

  assign x_sum = (PW+1)'(s2_pxc_q) + (PW+1)'(s2_pys_q);
  assign y_sum = (PW+1)'(s2_pyc_q) - (PW+1)'(s2_pxs_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_x_q <= pos_x_i;
      s0_y_q <= pos_y_i;
      s0_z_q <= pos_z_i;

      s1_dx_q <= DW'(s0_x_q) - DW'(cx);
      s1_dy_q <= DW'(s0_y_q) - DW'(cy);
      s1_dz_q <= DW'(s0_z_q) - DW'(cz);

      s2_pxc_q  <= s1_dx_q * rot_c;
      s2_pys_q  <= s1_dy_q * rot_s;
      s2_pyc_q  <= s1_dy_q * rot_c;
      s2_pxs_q  <= s1_dx_q * rot_s;
      s2_az_q   <= s1_dz_q[DW-1] ? DW'(-s1_dz_q) : DW'(s1_dz_q);
      s2_hyq_q  <= HW'(hy) * HW'(q);
      s2_hxq_q  <= HW'(hx) * HW'(q);
      s2_hxhy_q <= HW'(hx) * HW'(hy);

      // wraps like the 64-bit accumulator at the widest coordinates
      s3_x_q    <= XW'(x_sum);
      s3_y_q    <= XW'(y_sum);
      s3_az_q   <= s2_az_q;
      s3_hyq_q  <= s2_hyq_q;
      s3_hxq_q  <= s2_hxq_q;
      s3_hxhy_q <= s2_hxhy_q;

      s4_ax_q   <= s3_x_q[XW-1] ? XW'(-s3_x_q) : XW'(s3_x_q);
      s4_ay_q   <= s3_y_q[XW-1] ? XW'(-s3_y_q) : XW'(s3_y_q);
      s4_az_q   <= s3_az_q;
      s4_hyq_q  <= s3_hyq_q;
      s4_hxq_q  <= s3_hxq_q;
      s4_hxhy_q <= s3_hxhy_q;
    end
  end

  assign ax_o   = s4_ax_q;
  assign ay_o   = s4_ay_q;
  assign az_o   = s4_az_q;
  assign hyq_o  = s4_hyq_q;
  assign hxq_o  = s4_hxq_q;
  assign hxhy_o = s4_hxhy_q;

endmodule

[sv/rrcs_region.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrcs_region
// Region test: box limits, then the exact cross-multiplied ellipse test
// (A^2 + B^2 + C^2 <= R^2) through two pipelined multiplier layers and a
// sum stage. Seven register stages.
// ----------------------------------------------------------------------------
module rrcs_region #(
  parameter int COORD_WIDTH = 21
) (
  input  logic                                        clk_i,
  input  logic                                        en_i,
  input  rrcs_pkg::cfg_t                              cfg_i,
  input  logic [rrcs_pkg::rot_width(COORD_WIDTH)-1:0] ax_i,
  input  logic [rrcs_pkg::rot_width(COORD_WIDTH)-1:0] ay_i,
  input  logic [COORD_WIDTH:0]                        az_i,
  input  logic [2*COORD_WIDTH-1:0]                    hyq_i,
  input  logic [2*COORD_WIDTH-1:0]                    hxq_i,
  input  logic [2*COORD_WIDTH-1:0]                    hxhy_i,
  output logic                                        in_region_o
);
  import rrcs_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int XW   = rot_width(CW);
  localparam int HW   = 2 * CW;
  localparam int PKW  = 3 * CW;
  localparam int AMW  = XW + HW;        // A = |X| * hy * q
  localparam int CMW  = DW + HW;        // C = |dz| * hx * hy (scale 2^30 apart)
  localparam int RMW  = HW + CW;        // R = hx * hy * q   (scale 2^30 apart)
  localparam int SH   = 2 * ROT_FRAC;
  localparam int SQA  = 2 * AMW;
  localparam int SQC  = 2 * CMW + SH;
  localparam int SQR  = 2 * RMW + SH;
  localparam int SMAX = (SQA > SQC) ? ((SQA > SQR) ? SQA : SQR) : ((SQC > SQR) ? SQC : SQR);
  localparam int SW   = SMAX + 2;
  localparam int BCW  = (XW > CW + ROT_FRAC) ? XW : CW + ROT_FRAC;
  localparam int FD   = 2 * MUL_LAT + 1;

  typedef struct packed {
    logic box_ok;
    logic axial_ok;
  } geo_flags_t;

  logic [PKW-1:0] half_ext;
  logic [CW-1:0]  hx, hy, hz, q;
  logic [DW-1:0]  az_c;
  geo_flags_t     flg_d;
  geo_flags_t     flg_q [FD];

  logic [AMW-1:0]   a_p, b_p;
  logic [CMW-1:0]   c_p;
  logic [RMW-1:0]   r_p;
  logic [2*AMW-1:0] a_sq, b_sq;
  logic [2*CMW-1:0] c_sq;
  logic [2*RMW-1:0] r_sq;
  logic [SW-1:0]    lhs_q, rhs_q;
  logic             le;

  assign half_ext = PKW'(cfg_i.half_len);
  assign hx = half_ext[0 +: CW];
  assign hy = half_ext[CW +: CW];
  assign hz = half_ext[2*CW +: CW];
  assign q  = (cfg_i.shape == SHAPE_ELLIPSOID) ? hz : CW'(1);
  assign az_c = (cfg_i.shape == SHAPE_ELLIPSOID) ? az_i : '0;

  // box limits and the z slab shared with the cylinder
  always_comb begin
    flg_d.axial_ok = az_i <= DW'(hz);
    flg_d.box_ok   = (BCW'(ax_i) <= (BCW'(hx) << ROT_FRAC))
                  && (BCW'(ay_i) <= (BCW'(hy) << ROT_FRAC))
                  && flg_d.axial_ok;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flg_q[0] <= flg_d;
      for (int k = 1; k < FD; k++) begin
        flg_q[k] <= flg_q[k-1];
      end
    end
  end

  // weighted coordinates
  rrcs_mul #(.AW(XW), .BW(HW)) u_mul_a (
    .clk_i(clk_i), .en_i(en_i), .a_i(ax_i), .b_i(hyq_i), .p_o(a_p)
  );
  rrcs_mul #(.AW(XW), .BW(HW)) u_mul_b (
    .clk_i(clk_i), .en_i(en_i), .a_i(ay_i), .b_i(hxq_i), .p_o(b_p)
  );
  rrcs_mul #(.AW(DW), .BW(HW)) u_mul_c (
    .clk_i(clk_i), .en_i(en_i), .a_i(az_c), .b_i(hxhy_i), .p_o(c_p)
  );
  rrcs_mul #(.AW(HW), .BW(CW)) u_mul_r (
    .clk_i(clk_i), .en_i(en_i), .a_i(hxhy_i), .b_i(q), .p_o(r_p)
  );

  // squares
  rrcs_mul #(.AW(AMW), .BW(AMW)) u_sq_a (
    .clk_i(clk_i), .en_i(en_i), .a_i(a_p), .b_i(a_p), .p_o(a_sq)
  );
  rrcs_mul #(.AW(AMW), .BW(AMW)) u_sq_b (
    .clk_i(clk_i), .en_i(en_i), .a_i(b_p), .b_i(b_p), .p_o(b_sq)
  );
  rrcs_mul #(.AW(CMW), .BW(CMW)) u_sq_c (
    .clk_i(clk_i), .en_i(en_i), .a_i(c_p), .b_i(c_p), .p_o(c_sq)
  );
  rrcs_mul #(.AW(RMW), .BW(RMW)) u_sq_r (
    .clk_i(clk_i), .en_i(en_i), .a_i(r_p), .b_i(r_p), .p_o(r_sq)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lhs_q <= SW'(a_sq) + SW'(b_sq) + (SW'(c_sq) << SH);
      rhs_q <= SW'(r_sq) << SH;
    end
  end

  assign le = lhs_q <= rhs_q;

  always_comb begin
    case (cfg_i.shape)
      SHAPE_ELLIPSOID: in_region_o = (hx != '0) && (hy != '0) && (hz != '0) && le;
      SHAPE_BOX:       in_region_o = flg_q[FD-1].box_ok;
      SHAPE_CYLINDER:  in_region_o = (hx != '0) && (hy != '0) && le
                                  && flg_q[FD-1].axial_ok;
      default:         in_region_o = 1'b0;
    endcase
  end

endmodule

[sv/rotated_region_cell_selector_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_region_cell_selector_core
// Streams cells through a rotated ellipsoid / box / elliptic cylinder test and
// replaces the resistivity of free cells inside the region and select range.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one cell per transfer, point, resistivity and the
//   fixed flag. Output stream (m_axis): one result per cell, in order.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i;
//   write only while no cell is in flight.
//   Throughput: one cell per cycle unless the pipeline holds on a stall.
//   The datapath is 12 register stages deep (rotation, then two layers
//   of 32x32-limb multipliers and a sum stage), followed by the output
//   register.
//   Stall: while the output register waits on m_axis_tready, the pipeline
//   still advances into empty slots; it only holds when its last stage
//   carries a cell. Nothing is dropped or repeated.
//   Reset: clears all valid bits and loads the register defaults (ellipsoid,
//   center and half-lengths zero, no rotation, select range 0.1 to 10000,
//   replacement -1.0).
// ----------------------------------------------------------------------------
module rotated_region_cell_selector_core #(
  parameter int COORD_WIDTH = rrcs_pkg::COORD_WIDTH_DEF,
  parameter int RES_WIDTH   = rrcs_pkg::RES_WIDTH_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  // configuration
  input  logic                                          cfg_we_i,
  input  logic [rrcs_pkg::CFG_IDX_W-1:0]                cfg_idx_i,
  input  logic [rrcs_pkg::CFG_DATA_W-1:0]               cfg_wdata_i,
  // cell input
  input  logic                                          s_axis_tvalid,
  output logic                                          s_axis_tready,
  // pos_x, pos_y, pos_z, cell_resistivity
  input  logic [((3*COORD_WIDTH+RES_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
  // already_fixed
  input  logic [0:0]                                    s_axis_tuser,
  // result output
  output logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  // new_resistivity
  output logic [((RES_WIDTH+7)/8)*8-1:0]                m_axis_tdata,
  // chosen, fixed_out
  output logic [1:0]                                    m_axis_tuser
);
  import rrcs_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int XW   = rot_width(CW);
  localparam int HW   = 2 * CW;
  localparam int OUTW = ((RES_WIDTH + 7) / 8) * 8;
  localparam int CMPW = (RES_WIDTH > 32) ? RES_WIDTH : 32;
  localparam int NSTG = 5 + 2 * MUL_LAT + 1;

  typedef struct packed {
    logic signed [RES_WIDTH-1:0] res;
    logic                        fixed;
    logic                        in_range;
  } side_t;

  cfg_t cfg_q;

  logic            en;
  logic            out_ld;
  logic [NSTG-1:0] v_q;
  side_t           side_d [NSTG];
  side_t           side_q [NSTG];

  logic signed [CMPW-1:0] res_ext, min_ext, max_ext;

  logic [XW-1:0] ax, ay;
  logic [CW:0]   az;
  logic [HW-1:0] hyq, hxq, hxhy;
  logic          in_region;
  logic          chosen;

  logic                 out_valid_q;
  logic                 out_chosen_q;
  logic                 out_fixed_q;
  logic [RES_WIDTH-1:0] out_res_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SHAPE:  cfg_q.shape    <= cfg_wdata_i[1:0];
        CFG_CENTER: cfg_q.center   <= cfg_wdata_i[62:0];
        CFG_HALF:   cfg_q.half_len <= cfg_wdata_i[62:0];
        CFG_ROT:    cfg_q.rot      <= cfg_wdata_i;
        CFG_SELMIN: cfg_q.sel_min  <= $signed(cfg_wdata_i[31:0]);
        CFG_SELMAX: cfg_q.sel_max  <= $signed(cfg_wdata_i[31:0]);
        CFG_REPL:   cfg_q.repl     <= $signed(cfg_wdata_i[31:0]);
        default: ;
      endcase
    end
  end

  // pipeline moves unless its last stage holds a cell the output can't take
  assign out_ld = !out_valid_q || m_axis_tready;
  assign en     = out_ld || !v_q[NSTG-1];
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSTG-2:0], s_axis_tvalid};
    end
  end

  // resistivity, fixed flag and range check ride alongside the geometry
  assign res_ext = CMPW'($signed(side_q[0].res));
  assign min_ext = CMPW'($signed(cfg_q.sel_min));
  assign max_ext = CMPW'($signed(cfg_q.sel_max));

  always_comb begin
    side_d[0].res      = $signed(s_axis_tdata[3*CW +: RES_WIDTH]);
    side_d[0].fixed    = s_axis_tuser[0];
    side_d[0].in_range = 1'b0;
    for (int k = 1; k < NSTG; k++) begin
      side_d[k] = side_q[k-1];
    end
    side_d[1].in_range = (res_ext >= min_ext) && (res_ext <= max_ext);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q <= side_d;
    end
  end

  rrcs_rotate #(.COORD_WIDTH(CW)) u_rotate (
    .clk_i   (clk_i),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .pos_x_i ($signed(s_axis_tdata[0 +: CW])),
    .pos_y_i ($signed(s_axis_tdata[CW +: CW])),
    .pos_z_i ($signed(s_axis_tdata[2*CW +: CW])),
    .ax_o    (ax),
    .ay_o    (ay),
    .az_o    (az),
    .hyq_o   (hyq),
    .hxq_o   (hxq),
    .hxhy_o  (hxhy)
  );

  rrcs_region #(.COORD_WIDTH(CW)) u_region (
    .clk_i       (clk_i),
    .en_i        (en),
    .cfg_i       (cfg_q),
    .ax_i        (ax),
    .ay_i        (ay),
    .az_i        (az),
    .hyq_i       (hyq),
    .hxq_i       (hxq),
    .hxhy_i      (hxhy),
    .in_region_o (in_region)
  );

  assign chosen = !side_q[NSTG-1].fixed && side_q[NSTG-1].in_range && in_region;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= v_q[NSTG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_chosen_q <= chosen;
      out_fixed_q  <= side_q[NSTG-1].fixed || chosen;
      out_res_q    <= chosen ? RES_WIDTH'($signed(cfg_q.repl))
                             : side_q[NSTG-1].res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUTW'(out_res_q);
  assign m_axis_tuser  = {out_fixed_q, out_chosen_q};

endmodule
